/* design/prsd_pkg.sv */
// ---------------------------------------------------------------------------
// prsd_pkg
// shared types and constants of the palette run-length span decoder
// ---------------------------------------------------------------------------
`default_nettype none

package prsd_pkg;

  // default geometry and run field size
  localparam int DEF_LINE_WIDTH = 320;
  localparam int DEF_LINE_COUNT = 240;
  localparam int DEF_RUN_BITS   = 12;

  // fixed field widths
  localparam int PAL_DEPTH    = 16;
  localparam int PAL_IDX_W    = 4;
  localparam int COLOR_W      = 24;
  localparam int CODE_W       = 16;
  localparam int RUN_FIELD_W  = 12;
  localparam int SCALE_LOG2_W = 2;
  localparam int SCALE_W      = 4;
  localparam int SPAN_X_W     = 9;
  localparam int SPAN_Y_W     = 8;
  localparam int SPAN_WIDTH_W = 9;
  localparam int SPAN_H_W     = 4;
  localparam int CHAN_W       = 8;

  // stream widths
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 56;
  localparam int OUT_TUSER_W = 2;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // input word kinds
  localparam logic KIND_PALETTE = 1'b0;
  localparam logic KIND_RUN     = 1'b1;

  // classified input word
  typedef struct packed {
    logic                   is_run;
    logic [PAL_IDX_W-1:0]   index;
    logic [COLOR_W-1:0]     color;
    logic [RUN_FIELD_W-1:0] run;
  } cmd_t;

  // head of the queue as seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

  // one result span
  typedef struct packed {
    logic [SPAN_X_W-1:0]     x;
    logic [SPAN_Y_W-1:0]     y;
    logic [SPAN_WIDTH_W-1:0] width;
    logic [SPAN_H_W-1:0]     height;
    logic [CHAN_W-1:0]       red;
    logic [CHAN_W-1:0]       green;
    logic [CHAN_W-1:0]       blue;
    logic                    line_end;
    logic                    frame_end;
    logic                    overrun;
  } span_t;

endpackage

`default_nettype wire

/* design/prsd_front.sv */
// ---------------------------------------------------------------------------
// prsd_front
// accepts input words, classifies them and queues them for the back end
// ---------------------------------------------------------------------------
`default_nettype none

module prsd_front #(
  parameter int RUN_BITS = prsd_pkg::DEF_RUN_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // palette_index[3:0], palette_color[27:4], run_code[43:28]
  input  wire logic [prsd_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  // kind[0]
  input  wire logic                            s_axis_tuser,
  output prsd_pkg::head_t                      head,
  input  wire logic                            pop
);
  import prsd_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CODE_W-1:0] code;
  cmd_t              cmd_in;
  logic              push;

  cmd_t              queue [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  // classify: a run carries its palette entry in the top code bits
  always_comb begin
    code          = s_axis_tdata[43:28];
    cmd_in.is_run = (s_axis_tuser == KIND_RUN);
    cmd_in.color  = s_axis_tdata[27:4];
    cmd_in.run    = RUN_FIELD_W'(code[RUN_BITS-1:0]);
    if (cmd_in.is_run) begin
      cmd_in.index = code[CODE_W-1:CODE_W-PAL_IDX_W];
    end else begin
      cmd_in.index = s_axis_tdata[3:0];
    end
  end

  assign s_axis_tready = (count != CNT_W'(QUEUE_DEPTH));
  assign push          = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head = '{valid: (count != '0), cmd: queue[rd_ptr]};

`ifndef SYNTHESIS
  a_pop_needs_word: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("queue popped while empty");

  a_fill_tracks: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue fill count lost a word");

  a_head_holds: assert property (@(posedge clk) disable iff (rst)
    head.valid && !pop |=> head.valid && $stable(head.cmd))
    else $error("waiting head word changed");
`endif

endmodule

`default_nettype wire

/* design/prsd_back.sv */
// ---------------------------------------------------------------------------
// prsd_back
// palette store, position tracking and registered span output
// ---------------------------------------------------------------------------
`default_nettype none

module prsd_back #(
  parameter int LINE_WIDTH = prsd_pkg::DEF_LINE_WIDTH,
  parameter int LINE_COUNT = prsd_pkg::DEF_LINE_COUNT,
  parameter int RUN_BITS   = prsd_pkg::DEF_RUN_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire prsd_pkg::head_t                   head,
  output logic                                   pop,
  input  wire logic [prsd_pkg::SCALE_LOG2_W-1:0] scale_log2,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // span_x[8:0], span_y[16:9], span_width[25:17], span_height[29:26],
  // red[37:30], green[45:38], blue[53:46]
  output logic [prsd_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
  // line_end
  output logic                                   m_axis_tlast,
  // frame_end[0], overrun[1]
  output logic [prsd_pkg::OUT_TUSER_W-1:0]       m_axis_tuser
);
  import prsd_pkg::*;

  localparam int COL_W  = $clog2(LINE_WIDTH + 1);
  localparam int ROW_W  = $clog2(LINE_COUNT + 8);
  localparam int WIDE_W = RUN_BITS + 3;
  localparam int CMP_W  = (WIDE_W > COL_W) ? WIDE_W : COL_W;

  logic [COLOR_W-1:0] palette [PAL_DEPTH];
  logic [COL_W-1:0]   col;
  logic [ROW_W-1:0]   row;
  logic               out_valid;
  span_t              out_span;

  logic [RUN_BITS-1:0] run;
  logic [SCALE_W-1:0]  scale;
  logic [WIDE_W-1:0]   wide;
  logic [COL_W-1:0]    room;
  logic [ROW_W-1:0]    rows_left;
  logic [ROW_W-1:0]    row_sum;
  logic [COL_W-1:0]    width;
  logic [SPAN_H_W-1:0] height;
  logic [COLOR_W-1:0]  color;
  logic                overrun;
  logic                line_end;
  logic                frame_end;
  logic                load;
  span_t               span_next;

  always_comb begin
    run       = head.cmd.run[RUN_BITS-1:0];
    scale     = SCALE_W'(1) << scale_log2;
    wide      = WIDE_W'(run) << scale_log2;
    room      = COL_W'(LINE_WIDTH) - col;
    overrun   = CMP_W'(wide) > CMP_W'(room);
    width     = overrun ? room : COL_W'(wide);
    line_end  = (run != '0) && (CMP_W'(wide) >= CMP_W'(room));
    rows_left = ROW_W'(LINE_COUNT) - row;
    row_sum   = row + ROW_W'(scale);
    frame_end = line_end && (row_sum >= ROW_W'(LINE_COUNT));
    if (ROW_W'(scale) < rows_left) begin
      height = SPAN_H_W'(scale);
    end else begin
      height = SPAN_H_W'(rows_left);
    end
    color = palette[head.cmd.index];

    span_next.x         = SPAN_X_W'(col);
    span_next.y         = SPAN_Y_W'(row);
    span_next.width     = SPAN_WIDTH_W'(width);
    span_next.height    = height;
    span_next.red       = color[23:16];
    span_next.green     = color[15:8];
    span_next.blue      = color[7:0];
    span_next.line_end  = line_end;
    span_next.frame_end = frame_end;
    span_next.overrun   = overrun;
  end

  // palette writes never wait on the output side
  assign pop  = head.valid && (!head.cmd.is_run || !out_valid || m_axis_tready);
  assign load = pop && head.cmd.is_run;

  always_ff @(posedge clk) begin
    if (pop && !head.cmd.is_run) begin
      palette[head.cmd.index] <= head.cmd.color;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_span <= span_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      row       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        if (line_end) begin
          col <= '0;
          row <= frame_end ? '0 : row_sum;
        end else begin
          col <= col + width;
        end
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_TDATA_W'({out_span.blue, out_span.green, out_span.red,
                                       out_span.height, out_span.width,
                                       out_span.y, out_span.x});
  assign m_axis_tlast  = out_span.line_end;
  assign m_axis_tuser  = {out_span.overrun, out_span.frame_end};

`ifndef SYNTHESIS
  a_line_wraps: assert property (@(posedge clk) disable iff (rst)
    load && line_end |=> col == '0)
    else $error("column did not wrap at line end");

  a_row_holds: assert property (@(posedge clk) disable iff (rst)
    load && !line_end |=> row == $past(row))
    else $error("row moved inside a line");

  a_empty_run_holds: assert property (@(posedge clk) disable iff (rst)
    load && run == '0 |=> col == $past(col))
    else $error("zero-length run moved the column");
`endif

endmodule

`default_nettype wire

/* design/palette_rle_span_decoder_unit.sv */
// ---------------------------------------------------------------------------
// palette_rle_span_decoder_unit
// turns palette writes and run codes into coloured spans on a raster
// ---------------------------------------------------------------------------
// Each input word is either a palette write (tuser low) or a run code
// (tuser high). A run code yields one span at the current position, run
// times the scale wide and the scale high, clipped at the line end (then
// flagged as overrun) and at the bottom of the frame; a palette write yields
// nothing. The block takes one word per cycle while the output keeps up: a
// word taken enters a two-word queue, and when the back end pops a run code
// it loads the span into the output register, from which it is offered on the
// output. The one-word-per-cycle rate is set by the position update in the
// back end, where width, clip compare and column add are combinational for
// each run. While the output stalls, a palette write at the queue head still
// drains, but a run code waits at the head and words fill the queue behind
// it; once it is full the input drops ready, and after the stall clears the
// input stays not ready until the registered fill count drops. A palette
// write takes effect for every run code that follows it. Reading a palette
// entry never written gives an undefined colour. The scale register is
// written through the cfg channel, which is always ready; the user must
// write it only while the block is idle, as the block does not enforce this.
// ---------------------------------------------------------------------------
`default_nettype none

module palette_rle_span_decoder_unit #(
  parameter int LINE_WIDTH = prsd_pkg::DEF_LINE_WIDTH,
  parameter int LINE_COUNT = prsd_pkg::DEF_LINE_COUNT,
  parameter int RUN_BITS   = prsd_pkg::DEF_RUN_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // scale register write channel
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  // scale_log2[1:0]
  input  wire logic [prsd_pkg::SCALE_LOG2_W-1:0] cfg_data,
  // input words
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // palette_index[3:0], palette_color[27:4], run_code[43:28]
  input  wire logic [prsd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // kind[0]
  input  wire logic                              s_axis_tuser,
  // output spans
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // span_x[8:0], span_y[16:9], span_width[25:17], span_height[29:26],
  // red[37:30], green[45:38], blue[53:46]
  output logic [prsd_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
  // line_end
  output logic                                   m_axis_tlast,
  // frame_end[0], overrun[1]
  output logic [prsd_pkg::OUT_TUSER_W-1:0]       m_axis_tuser
);
  import prsd_pkg::*;

  logic [SCALE_LOG2_W-1:0] scale_log2;
  head_t                   head;
  logic                    pop;

  // scale register, factor 1 after reset
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_log2 <= '0;
    end else if (cfg_valid) begin
      scale_log2 <= cfg_data;
    end
  end

  // front end: classify and queue
  prsd_front #(
    .RUN_BITS (RUN_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .head          (head),
    .pop           (pop)
  );

  // back end: palette, position and span register
  prsd_back #(
    .LINE_WIDTH (LINE_WIDTH),
    .LINE_COUNT (LINE_COUNT),
    .RUN_BITS   (RUN_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .pop           (pop),
    .scale_log2    (scale_log2),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire
